[design/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, codes and word types of the ray/sphere intersection block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // Field widths (Q16.16 coordinates)
    localparam int unsigned COORD_W = 32;
    localparam int unsigned RAD_W   = 31;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // Quadratic coefficient widths
    localparam int unsigned DIFF_W  = COORD_W + 1;   // origin - center
    localparam int unsigned A_W     = 64;            // |d|^2, unsigned
    localparam int unsigned H_W     = 66;            // d.w, signed
    localparam int unsigned HMAG_W  = H_W - 1;
    localparam int unsigned C_W     = 68;            // |w|^2 - r^2, signed
    localparam int unsigned CMAG_W  = C_W - 1;
    localparam int unsigned SQ_W    = 132;           // h^2 and a*|c|
    localparam int unsigned DISC_W  = 136;           // discriminant, signed

    // Square root
    localparam int unsigned SQRT_STEPS = DISC_W / 2;
    localparam int unsigned ROOT_W     = SQRT_STEPS;
    localparam int unsigned REM_W      = ROOT_W + 2;

    // Root division
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned NUM_W  = 70;             // -h +/- s, signed
    localparam int unsigned NMAG_W = NUM_W - 1;
    localparam int unsigned QUO_W  = 33;
    localparam int unsigned SHIFT  = QUO_W - FRAC_W;

    localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] T_MIN = 32'sh8000_0000;
    localparam logic [RAD_W-1:0]          RAD_RESET = 31'd65536;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ENTER = 2'd1,
        KIND_EXIT  = 2'd2
    } hit_kind_t;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } reg_idx_t;

    // Sphere configuration
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          radius;
    } rsi_cfg_t;

    // Classified ray, front to back
    typedef struct packed {
        logic signed [DISC_W-1:0]  disc;
        logic signed [H_W-1:0]     h;
        logic [A_W-1:0]            a;
        logic signed [COORD_W-1:0] t_low;
        logic signed [COORD_W-1:0] t_high;
        logic                      miss;
    } rsi_job_t;

endpackage

[design/rsi_ray_if.sv]
// ----------------------------------------------------------------------------
// rsi_ray_if
// Ray channel: valid/ready handshake with origin, direction and window.
// ----------------------------------------------------------------------------
interface rsi_ray_if
    import rsi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] t_low;
    logic signed [COORD_W-1:0] t_high;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_low, t_high,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_low, t_high,
        output ready
    );
endinterface

[design/rsi_hit_if.sv]
// ----------------------------------------------------------------------------
// rsi_hit_if
// Hit channel: valid/ready handshake with hit kind and ray parameter.
// ----------------------------------------------------------------------------
interface rsi_hit_if
    import rsi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                hit_kind;
    logic signed [COORD_W-1:0] hit_t;

    modport source (
        output valid, hit_kind, hit_t,
        input  ready
    );
    modport sink (
        input  valid, hit_kind, hit_t,
        output ready
    );
endinterface

[design/rsi_front.sv]
// ----------------------------------------------------------------------------
// rsi_front
// Seven-stage front pipe: forms a, h, c and the discriminant, flags misses.
// ----------------------------------------------------------------------------
module rsi_front
    import rsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rsi_cfg_t cfg,
    rsi_ray_if.sink  ray,
    output logic     job_valid,
    input  logic     job_ready,
    output rsi_job_t job
);

    localparam int unsigned NST = 7;

    logic [NST-1:0] vld_reg;
    logic           en;

    // Stage 1: direction, origin minus center
    logic signed [COORD_W-1:0] d1_reg [3];
    logic signed [DIFF_W-1:0]  w1_reg [3];
    logic [RAD_W-1:0]          r1_reg;
    // Stage 2: products
    logic signed [2*COORD_W-1:0]      aa2_reg [3];
    logic signed [COORD_W+DIFF_W-1:0] hh2_reg [3];
    logic signed [2*DIFF_W-1:0]       cc2_reg [3];
    logic [2*RAD_W-1:0]               rr2_reg;
    // Stage 4: magnitudes
    logic [HMAG_W-1:0]  hmag4_reg;
    logic [CMAG_W-1:0]  cmag4_reg;
    logic               cneg4_reg;
    logic signed [C_W-1:0] c3_reg;
    // Stage 5: partial products
    logic [63:0] phh5_reg;
    logic [64:0] phl5_reg;
    logic [65:0] pll5_reg;
    logic [64:0] qhh5_reg;
    logic [65:0] qhl5_reg;
    logic [64:0] qlh5_reg;
    logic [65:0] qll5_reg;
    logic        cneg5_reg;
    // Stage 6: h^2 and a*|c|
    logic [SQ_W-1:0] hsq6_reg;
    logic [SQ_W-1:0] ac6_reg;
    logic            cneg6_reg;
    // Stage 7: discriminant
    logic signed [DISC_W-1:0] disc7_reg;
    logic                     miss7_reg;
    // Carried fields
    logic [A_W-1:0]            a_reg  [5];
    logic signed [H_W-1:0]     h_reg  [5];
    logic signed [COORD_W-1:0] lo_reg [NST];
    logic signed [COORD_W-1:0] hi_reg [NST];

    logic signed [DISC_W-1:0] disc_c;
    logic                     miss_c;

    assign en        = !vld_reg[NST-1] || job_ready;
    assign ray.ready = en;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], ray.valid};
        end
    end

    // Discriminant and classification
    always_comb
    begin
        disc_c = cneg6_reg ? DISC_W'(hsq6_reg) + DISC_W'(ac6_reg)
                           : DISC_W'(hsq6_reg) - DISC_W'(ac6_reg);
        miss_c = disc_c[DISC_W-1] || (disc_c == '0) || (a_reg[3] == '0);
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            d1_reg[0] <= ray.dir_x;
            d1_reg[1] <= ray.dir_y;
            d1_reg[2] <= ray.dir_z;
            w1_reg[0] <= DIFF_W'(ray.origin_x) - DIFF_W'(cfg.center_x);
            w1_reg[1] <= DIFF_W'(ray.origin_y) - DIFF_W'(cfg.center_y);
            w1_reg[2] <= DIFF_W'(ray.origin_z) - DIFF_W'(cfg.center_z);
            r1_reg    <= cfg.radius;
            lo_reg[0] <= ray.t_low;
            hi_reg[0] <= ray.t_high;
            for (int i = 1; i < NST; i++)
            begin
                lo_reg[i] <= lo_reg[i-1];
                hi_reg[i] <= hi_reg[i-1];
            end

            // stage 2
            for (int i = 0; i < 3; i++)
            begin
                aa2_reg[i] <= d1_reg[i] * d1_reg[i];
                hh2_reg[i] <= d1_reg[i] * w1_reg[i];
                cc2_reg[i] <= w1_reg[i] * w1_reg[i];
            end
            rr2_reg <= r1_reg * r1_reg;

            // stage 3
            a_reg[0] <= A_W'(aa2_reg[0]) + A_W'(aa2_reg[1]) + A_W'(aa2_reg[2]);
            h_reg[0] <= H_W'(hh2_reg[0]) + H_W'(hh2_reg[1]) + H_W'(hh2_reg[2]);
            c3_reg   <= C_W'(cc2_reg[0]) + C_W'(cc2_reg[1]) + C_W'(cc2_reg[2])
                        - C_W'(rr2_reg);
            for (int i = 1; i < 5; i++)
            begin
                a_reg[i] <= a_reg[i-1];
                h_reg[i] <= h_reg[i-1];
            end

            // stage 4
            hmag4_reg <= h_reg[0][H_W-1] ? HMAG_W'(-h_reg[0]) : HMAG_W'(h_reg[0]);
            cmag4_reg <= c3_reg[C_W-1] ? CMAG_W'(-c3_reg) : CMAG_W'(c3_reg);
            cneg4_reg <= c3_reg[C_W-1];

            // stage 5: split into 32/33/34-bit pieces
            phh5_reg  <= hmag4_reg[HMAG_W-1:33] * hmag4_reg[HMAG_W-1:33];
            phl5_reg  <= hmag4_reg[HMAG_W-1:33] * hmag4_reg[32:0];
            pll5_reg  <= hmag4_reg[32:0] * hmag4_reg[32:0];
            qhh5_reg  <= a_reg[1][A_W-1:32] * cmag4_reg[CMAG_W-1:34];
            qhl5_reg  <= a_reg[1][A_W-1:32] * cmag4_reg[33:0];
            qlh5_reg  <= a_reg[1][31:0] * cmag4_reg[CMAG_W-1:34];
            qll5_reg  <= a_reg[1][31:0] * cmag4_reg[33:0];
            cneg5_reg <= cneg4_reg;

            // stage 6
            hsq6_reg  <= (SQ_W'(phh5_reg) << 66) + (SQ_W'(phl5_reg) << 34)
                         + SQ_W'(pll5_reg);
            ac6_reg   <= (SQ_W'(qhh5_reg) << 66) + (SQ_W'(qhl5_reg) << 32)
                         + (SQ_W'(qlh5_reg) << 34) + SQ_W'(qll5_reg);
            cneg6_reg <= cneg5_reg;

            // stage 7: misses carry a zero discriminant
            disc7_reg <= miss_c ? '0 : disc_c;
            miss7_reg <= miss_c;
        end
    end

    assign job_valid  = vld_reg[NST-1];
    assign job.disc   = disc7_reg;
    assign job.h      = h_reg[4];
    assign job.a      = a_reg[4];
    assign job.t_low  = lo_reg[NST-1];
    assign job.t_high = hi_reg[NST-1];
    assign job.miss   = miss7_reg;

endmodule

[design/rsi_queue.sv]
// ----------------------------------------------------------------------------
// rsi_queue
// Small FIFO that decouples the front pipe from the back pipe.
// ----------------------------------------------------------------------------
module rsi_queue
    import rsi_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rsi_job_t in_job,
    output logic     out_valid,
    input  logic     out_ready,
    output rsi_job_t out_job
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rsi_job_t         mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

[design/rsi_back.sv]
// ----------------------------------------------------------------------------
// rsi_back
// Back pipe: digit-by-digit square root, two restoring root divisions,
// saturation and the window test.
// ----------------------------------------------------------------------------
module rsi_back
    import rsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rsi_job_t in_job,
    rsi_hit_if.source hit
);

    localparam int unsigned NST   = SQRT_STEPS + 2 + QUO_W + 2;
    localparam int unsigned LSQ   = SQRT_STEPS - 1;
    localparam int unsigned LDV   = QUO_W - 1;
    localparam int unsigned TRY_W = REM_W + 2;
    localparam int unsigned CMP_W = A_W + SHIFT;

    typedef struct packed {
        logic signed [H_W-1:0]     h;
        logic [A_W-1:0]            a;
        logic signed [COORD_W-1:0] t_low;
        logic signed [COORD_W-1:0] t_high;
        logic                      miss;
    } carry_t;

    logic [NST-1:0] vld_reg;
    logic           en;

    // Square root stages
    logic [DISC_W-1:0] rad_reg  [SQRT_STEPS];
    logic [REM_W-1:0]  srem_reg [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS];
    carry_t            sc_reg   [SQRT_STEPS];

    // Numerators (index 0 near root, 1 far root)
    logic signed [NUM_W-1:0] num_reg [2];
    carry_t                  nc_reg;
    logic [NMAG_W-1:0]       mag_c   [2];
    logic                    neg_c   [2];

    // Division setup
    logic [A_W-1:0]   mrem_reg [2];
    logic [QUO_W-1:0] mlow_reg [2];
    logic             mneg_reg [2];
    logic             movf_reg [2];
    carry_t           mc_reg;

    // Division stages
    logic [A_W-1:0]   drem_reg [QUO_W][2];
    logic [QUO_W-1:0] dlow_reg [QUO_W][2];
    logic [QUO_W-1:0] dq_reg   [QUO_W][2];
    logic             dneg_reg [QUO_W][2];
    logic             dovf_reg [QUO_W][2];
    carry_t           dc_reg   [QUO_W];

    // Saturated roots and result
    logic signed [COORD_W-1:0] ts_reg [2];
    carry_t                    tc_reg;
    hit_kind_t                 kind_reg;
    logic signed [COORD_W-1:0] t_reg;
    hit_kind_t                 kind_c;
    logic signed [COORD_W-1:0] t_c;

    // Floor of a signed quotient from its magnitude parts, clamped to 32 bits
    function automatic logic signed [COORD_W-1:0] sat_root(
        input logic             neg,
        input logic             ovf,
        input logic [QUO_W-1:0] q,
        input logic             rnz
    );
        logic signed [COORD_W-1:0] res;
        logic                      big;
        begin
            if (ovf)
            begin
                res = neg ? T_MIN : T_MAX;
            end
            else if (!neg)
            begin
                res = (q[QUO_W-1] || q[QUO_W-2]) ? T_MAX : COORD_W'(q);
            end
            else
            begin
                big = q[QUO_W-1] || (q[QUO_W-2] && ((q[QUO_W-3:0] != '0) || rnz));
                res = big ? T_MIN : -COORD_W'(q) - COORD_W'(rnz);
            end
            return res;
        end
    endfunction

    // Open window test, t_high at maximum is unbounded
    function automatic logic in_window(
        input logic signed [COORD_W-1:0] t,
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        begin
            return (t > lo) && ((hi == T_MAX) || (t < hi));
        end
    endfunction

    assign en        = !vld_reg[NST-1] || hit.ready;
    assign in_ready  = en;
    assign hit.valid = vld_reg[NST-1];
    assign hit.hit_kind = kind_reg;
    assign hit.hit_t    = t_reg;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Square root, two radicand bits per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [DISC_W-1:0] rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        carry_t            c_in;
        logic [TRY_W-1:0]  part;
        logic [TRY_W-1:0]  trial;

        if (k == 0)
        begin : g_first
            assign rad_in  = in_job.disc;
            assign rem_in  = '0;
            assign root_in = '0;
            assign c_in    = '{h: in_job.h, a: in_job.a, t_low: in_job.t_low,
                               t_high: in_job.t_high, miss: in_job.miss};
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = srem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign c_in    = sc_reg[k-1];
        end

        assign part  = {rem_in, rad_in[DISC_W-1 -: 2]};
        assign trial = TRY_W'({root_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k] <= rad_in << 2;
                sc_reg[k]  <= c_in;
                if (part >= trial)
                begin
                    srem_reg[k] <= REM_W'(part - trial);
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg[k] <= part[REM_W-1:0];
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Magnitude and sign of both numerators
    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            neg_c[r] = num_reg[r][NUM_W-1];
            mag_c[r] = neg_c[r] ? NMAG_W'(-num_reg[r]) : NMAG_W'(num_reg[r]);
        end
    end

    // Numerators, then division setup with overflow precheck
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= -NUM_W'(sc_reg[LSQ].h) - NUM_W'(root_reg[LSQ]);
            num_reg[1] <= -NUM_W'(sc_reg[LSQ].h) + NUM_W'(root_reg[LSQ]);
            nc_reg     <= sc_reg[LSQ];

            for (int r = 0; r < 2; r++)
            begin
                mneg_reg[r] <= neg_c[r];
                movf_reg[r] <= CMP_W'(mag_c[r]) >= {nc_reg.a, {SHIFT{1'b0}}};
                mrem_reg[r] <= A_W'(mag_c[r] >> SHIFT);
                mlow_reg[r] <= {mag_c[r][SHIFT-1:0], {FRAC_W{1'b0}}};
            end
            mc_reg <= nc_reg;
        end
    end

    // Restoring division, one quotient bit per stage for both roots
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        logic [A_W-1:0]   rem_in  [2];
        logic [QUO_W-1:0] low_in  [2];
        logic [QUO_W-1:0] q_in    [2];
        logic             neg_in  [2];
        logic             ovf_in  [2];
        carry_t           c_in;
        logic [A_W:0]     part    [2];

        if (j == 0)
        begin : g_first
            for (genvar r = 0; r < 2; r++)
            begin : g_root
                assign rem_in[r] = mrem_reg[r];
                assign low_in[r] = mlow_reg[r];
                assign q_in[r]   = '0;
                assign neg_in[r] = mneg_reg[r];
                assign ovf_in[r] = movf_reg[r];
            end
            assign c_in = mc_reg;
        end
        else
        begin : g_next
            for (genvar r = 0; r < 2; r++)
            begin : g_root
                assign rem_in[r] = drem_reg[j-1][r];
                assign low_in[r] = dlow_reg[j-1][r];
                assign q_in[r]   = dq_reg[j-1][r];
                assign neg_in[r] = dneg_reg[j-1][r];
                assign ovf_in[r] = dovf_reg[j-1][r];
            end
            assign c_in = dc_reg[j-1];
        end

        for (genvar r = 0; r < 2; r++)
        begin : g_part
            assign part[r] = {rem_in[r], low_in[r][QUO_W-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int r = 0; r < 2; r++)
                begin
                    dlow_reg[j][r] <= low_in[r] << 1;
                    dneg_reg[j][r] <= neg_in[r];
                    dovf_reg[j][r] <= ovf_in[r];
                    if (part[r] >= {1'b0, c_in.a})
                    begin
                        drem_reg[j][r] <= A_W'(part[r] - {1'b0, c_in.a});
                        dq_reg[j][r]   <= {q_in[r][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[j][r] <= part[r][A_W-1:0];
                        dq_reg[j][r]   <= {q_in[r][QUO_W-2:0], 1'b0};
                    end
                end
                dc_reg[j] <= c_in;
            end
        end
    end

    // Near root wins if inside the window, else the far root
    always_comb
    begin
        kind_c = KIND_NONE;
        t_c    = '0;
        if (!tc_reg.miss)
        begin
            if (in_window(ts_reg[0], tc_reg.t_low, tc_reg.t_high))
            begin
                kind_c = KIND_ENTER;
                t_c    = ts_reg[0];
            end
            else if (in_window(ts_reg[1], tc_reg.t_low, tc_reg.t_high))
            begin
                kind_c = KIND_EXIT;
                t_c    = ts_reg[1];
            end
        end
    end

    // Saturation and output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 2; r++)
            begin
                ts_reg[r] <= sat_root(dneg_reg[LDV][r], dovf_reg[LDV][r], dq_reg[LDV][r],
                                      drem_reg[LDV][r] != '0);
            end
            tc_reg   <= dc_reg[LDV];
            kind_reg <= kind_c;
            t_reg    <= t_c;
        end
    end

endmodule

[design/ray_sphere_intersect.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray against configured sphere, Q16.16, one ray per clock while hit is not stalled.
// ----------------------------------------------------------------------------
// Rays come in on the ray channel (valid/ready); each accepted word gives
// exactly one word on the hit channel: hit_kind none, enter at the near
// root or exit at the far root, with hit_t the saturated ray parameter.
// Sphere center and radius sit in four APB registers (center x, y, z and
// radius at byte addresses 0, 4, 8, 12); write them only while no ray is
// in flight. pready is tied high.
// Throughput: one ray per cycle while hit is not stalled. From acceptance
// to the result on hit a ray passes a 7-stage front pipe, the queue, a
// 68-stage square root (two radicand bits per stage), a
// 33-stage restoring divider (one quotient bit per stage) and 4 stages of
// numerator, saturation and window logic.
// When hit is stalled the back pipe holds; the front keeps taking rays
// until the queue between them fills, then ray.ready drops.
// Reset clears all valid state and the queue and loads center 0 and
// radius 1.0; rays in flight are dropped.
// ----------------------------------------------------------------------------
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    rsi_ray_if.sink           ray,
    rsi_hit_if.source         hit,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] cz_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic                      wr_en;
    reg_idx_t                  reg_idx;
    rsi_cfg_t                  cfg;

    logic     f_valid;
    logic     f_ready;
    rsi_job_t f_job;
    logic     q_valid;
    logic     q_ready;
    rsi_job_t q_job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= RAD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CENTER_X: cx_reg  <= pwdata;
                REG_CENTER_Y: cy_reg  <= pwdata;
                REG_CENTER_Z: cz_reg  <= pwdata;
                REG_RADIUS:   rad_reg <= pwdata[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            REG_CENTER_X: prdata = cx_reg;
            REG_CENTER_Y: prdata = cy_reg;
            REG_CENTER_Z: prdata = cz_reg;
            REG_RADIUS:   prdata = DATA_W'(rad_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.center_x = cx_reg;
    assign cfg.center_y = cy_reg;
    assign cfg.center_z = cz_reg;
    assign cfg.radius   = rad_reg;

    rsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ray       (ray),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    rsi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    rsi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_job   (q_job),
        .hit      (hit)
    );

`ifndef SYNTHESIS
    // A word without a hit carries a zero parameter
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid && (hit.hit_kind == KIND_NONE) |-> hit.hit_t == '0)
        else $error("hit word of kind none has nonzero hit_t");

    // A root clamped to the minimum never passes the strict lower bound
    a_no_min_hit: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid && (hit.hit_kind != KIND_NONE) |-> hit.hit_t != T_MIN)
        else $error("hit reported at saturated minimum parameter");

    // Radius write lands in the register
    a_radius_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && (reg_idx == REG_RADIUS) |=> rad_reg == $past(pwdata[RAD_W-1:0]))
        else $error("radius register did not take the written value");
`endif

endmodule
